// ===== design/kip_pkg.sv =====
// Shared types and constants of the key image packetizer.
`default_nettype none

package kip_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W = 16;
  localparam int LEN_W = 16;
  localparam int PKT_W = 12;
  localparam int PITCH_W = 12;
  localparam int PART_W = 5;
  localparam int KEY_W = 4;
  localparam int HIDX_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int FIRST_HDR_LEN = 20;
  localparam int LATER_HDR_LEN = 5;
  localparam logic [KEY_W-1:0] MAX_KEY = 4'd8;

  localparam logic [BYTE_W-1:0] HDR_REPORT_ID = 8'h14;
  localparam logic [BYTE_W-1:0] HDR_B1 = 8'hff;
  localparam logic [BYTE_W-1:0] HDR_B2 = 8'h02;
  localparam logic [BYTE_W-1:0] HDR_B3 = 8'h2b;
  localparam logic [BYTE_W-1:0] HDR_ONE = 8'h01;
  localparam logic [BYTE_W-1:0] HDR_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] FLAG_BASE = 8'b0010_0000;
  localparam logic [BYTE_W-1:0] FLAG_FIRST = 8'b1000_0000;
  localparam logic [BYTE_W-1:0] FLAG_LAST = 8'b0100_0000;

  localparam logic [POS_W-1:0] ORIGIN_X_RST = 16'd23;
  localparam logic [POS_W-1:0] ORIGIN_Y_RST = 16'd6;
  localparam logic [PITCH_W-1:0] KEY_PITCH_RST = 12'd158;
  localparam logic [POS_W-1:0] TILE_SIZE_RST = 16'd118;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PITCH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE = 2'd3;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_LATER,
    CMD_FIRST
  } kip_cmd_t;

  typedef struct packed {
    kip_cmd_t kind;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] flag;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [LEN_W-1:0] len;
    logic pe;
    logic [PKT_W-1:0] fill;
    logic ie;
  } kip_entry_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } kip_q_status_t;

endpackage

`default_nettype wire

// ===== design/kip_front.sv =====
// Front end: tracks image and packet state and turns each input word of a valid-key image into a command.
`default_nettype none

module kip_front #(
  parameter int PACKET_SIZE = 4095,
  parameter int GRID_COLUMNS = 3
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic accept,
  input  wire logic [kip_pkg::BYTE_W-1:0] data_byte,
  input  wire logic [kip_pkg::KEY_W-1:0] key_index,
  input  wire logic [kip_pkg::LEN_W-1:0] image_length,
  input  wire logic [kip_pkg::POS_W-1:0] origin_x,
  input  wire logic [kip_pkg::POS_W-1:0] origin_y,
  input  wire logic [kip_pkg::PITCH_W-1:0] key_pitch,
  output kip_pkg::kip_entry_t entry,
  output logic push
);

  localparam int NKEYS = int'(kip_pkg::MAX_KEY) + 1;
  localparam logic [kip_pkg::PKT_W-1:0] CAP1 =
      kip_pkg::PKT_W'(PACKET_SIZE - kip_pkg::FIRST_HDR_LEN);
  localparam logic [kip_pkg::PKT_W-1:0] CAP5 =
      kip_pkg::PKT_W'(PACKET_SIZE - kip_pkg::LATER_HDR_LEN);

  logic [2:0] col_tab [NKEYS];
  logic [3:0] row_tab [NKEYS];

  for (genvar j = 0; j < NKEYS; j++) begin : g_grid
    localparam int COL = j % GRID_COLUMNS;
    localparam int ROW = j / GRID_COLUMNS;
    assign col_tab[j] = 3'(COL);
    assign row_tab[j] = 4'(ROW);
  end

  logic [kip_pkg::LEN_W-1:0] remaining_image, remaining_image_next;
  logic [kip_pkg::PKT_W-1:0] packet_bytes_left, packet_bytes_left_next;
  logic [kip_pkg::PART_W-1:0] part_number, part_number_next;
  logic [kip_pkg::PKT_W-1:0] pending_fill, pending_fill_next;
  logic drop_image, drop_image_next;

  logic [kip_pkg::LEN_W-1:0] len_adj;
  logic key_ok;
  logic [2:0] col;
  logic [3:0] row;
  logic [kip_pkg::PKT_W-1:0] n1, n5;
  logic [kip_pkg::PART_W-1:0] part_inc;

  always_comb begin
    len_adj = (image_length == '0) ? kip_pkg::LEN_W'(1) : image_length;
    key_ok = key_index <= kip_pkg::MAX_KEY;
    col = key_ok ? col_tab[key_index] : '0;
    row = key_ok ? row_tab[key_index] : '0;
    n1 = (len_adj < {4'b0, CAP1}) ? len_adj[kip_pkg::PKT_W-1:0] : CAP1;
    n5 = (remaining_image < {4'b0, CAP5}) ? remaining_image[kip_pkg::PKT_W-1:0] : CAP5;
    part_inc = part_number + kip_pkg::PART_W'(1);

    remaining_image_next = remaining_image;
    packet_bytes_left_next = packet_bytes_left;
    part_number_next = part_number;
    pending_fill_next = pending_fill;
    drop_image_next = drop_image;
    push = 1'b0;

    entry.kind = kip_pkg::CMD_DATA;
    entry.data = data_byte;
    entry.flag = '0;
    entry.x = origin_x + 16'(16'(col) * 16'(key_pitch));
    entry.y = origin_y + 16'(16'(row) * 16'(key_pitch));
    entry.len = len_adj;
    entry.pe = 1'b0;
    entry.fill = '0;
    entry.ie = 1'b0;

    priority if (remaining_image == '0) begin
      if (!key_ok) begin
        remaining_image_next = len_adj - kip_pkg::LEN_W'(1);
        drop_image_next = len_adj != kip_pkg::LEN_W'(1);
        packet_bytes_left_next = '0;
        pending_fill_next = '0;
      end else begin
        push = accept;
        drop_image_next = 1'b0;
        part_number_next = kip_pkg::PART_W'(1);
        packet_bytes_left_next = n1 - kip_pkg::PKT_W'(1);
        remaining_image_next = len_adj - kip_pkg::LEN_W'(1);
        pending_fill_next = CAP1 - n1;
        entry.kind = kip_pkg::CMD_FIRST;
        entry.flag = kip_pkg::FLAG_FIRST | kip_pkg::FLAG_BASE | kip_pkg::HDR_ONE |
                     ((len_adj <= {4'b0, CAP1}) ? kip_pkg::FLAG_LAST : '0);
        entry.pe = n1 == kip_pkg::PKT_W'(1);
        entry.fill = entry.pe ? (CAP1 - n1) : '0;
        entry.ie = len_adj == kip_pkg::LEN_W'(1);
      end
    end else if (drop_image) begin
      remaining_image_next = remaining_image - kip_pkg::LEN_W'(1);
      if (remaining_image == kip_pkg::LEN_W'(1)) begin
        drop_image_next = 1'b0;
      end
    end else if (packet_bytes_left == '0) begin
      push = accept;
      part_number_next = part_inc;
      packet_bytes_left_next = n5 - kip_pkg::PKT_W'(1);
      remaining_image_next = remaining_image - kip_pkg::LEN_W'(1);
      pending_fill_next = CAP5 - n5;
      entry.kind = kip_pkg::CMD_LATER;
      entry.flag = {3'b0, part_inc} | kip_pkg::FLAG_BASE |
                   ((remaining_image <= {4'b0, CAP5}) ? kip_pkg::FLAG_LAST : '0);
      entry.pe = n5 == kip_pkg::PKT_W'(1);
      entry.fill = entry.pe ? (CAP5 - n5) : '0;
      entry.ie = remaining_image == kip_pkg::LEN_W'(1);
    end else begin
      push = accept;
      packet_bytes_left_next = packet_bytes_left - kip_pkg::PKT_W'(1);
      remaining_image_next = remaining_image - kip_pkg::LEN_W'(1);
      entry.pe = packet_bytes_left == kip_pkg::PKT_W'(1);
      entry.fill = entry.pe ? pending_fill : '0;
      entry.ie = remaining_image == kip_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_image <= '0;
      packet_bytes_left <= '0;
      part_number <= '0;
      pending_fill <= '0;
      drop_image <= 1'b0;
    end else if (accept) begin
      remaining_image <= remaining_image_next;
      packet_bytes_left <= packet_bytes_left_next;
      part_number <= part_number_next;
      pending_fill <= pending_fill_next;
      drop_image <= drop_image_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/kip_queue.sv =====
// Two-entry command queue between the front end and the byte emitter.
`default_nettype none

module kip_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire kip_pkg::kip_entry_t push_entry,
  input  wire logic pop,
  output kip_pkg::kip_entry_t head,
  output kip_pkg::kip_q_status_t status
);

  kip_pkg::kip_entry_t slots [2];
  logic wptr, rptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_comb begin
    head = slots[rptr];
    status.full = count == 2'd2;
    status.head_valid = count != 2'd0;
  end

endmodule

`default_nettype wire

// ===== design/kip_back.sv =====
// Back end: expands each command into its header words, if any, and a payload word.
`default_nettype none

module kip_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire kip_pkg::kip_entry_t head,
  input  wire logic head_valid,
  input  wire logic [kip_pkg::POS_W-1:0] tile_size,
  output logic pop,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [kip_pkg::BYTE_W-1:0] out_byte,
  output logic packet_end,
  output logic [kip_pkg::PKT_W-1:0] zero_fill,
  output logic image_end,
  output logic run_last
);

  logic [kip_pkg::HIDX_W-1:0] hidx;
  logic [kip_pkg::HIDX_W-1:0] hdr_len;
  logic at_payload;
  logic load;
  logic [kip_pkg::BYTE_W-1:0] hdr_byte;

  always_comb begin
    unique case (head.kind)
      kip_pkg::CMD_FIRST: hdr_len = kip_pkg::HIDX_W'(kip_pkg::FIRST_HDR_LEN);
      kip_pkg::CMD_LATER: hdr_len = kip_pkg::HIDX_W'(kip_pkg::LATER_HDR_LEN);
      default:            hdr_len = '0;
    endcase
    at_payload = hidx == hdr_len;
    load = head_valid && (!out_valid || !out_stall);
    pop = load && at_payload;

    unique case (hidx)
      5'd0:    hdr_byte = kip_pkg::HDR_REPORT_ID;
      5'd1:    hdr_byte = kip_pkg::HDR_B1;
      5'd2:    hdr_byte = kip_pkg::HDR_B2;
      5'd3:    hdr_byte = kip_pkg::HDR_B3;
      5'd4:    hdr_byte = head.flag;
      5'd5:    hdr_byte = kip_pkg::HDR_ONE;
      5'd7:    hdr_byte = kip_pkg::HDR_ONE;
      5'd9:    hdr_byte = head.x[15:8];
      5'd10:   hdr_byte = head.x[7:0];
      5'd11:   hdr_byte = head.y[15:8];
      5'd12:   hdr_byte = head.y[7:0];
      5'd13:   hdr_byte = tile_size[15:8];
      5'd14:   hdr_byte = tile_size[7:0];
      5'd15:   hdr_byte = tile_size[15:8];
      5'd16:   hdr_byte = tile_size[7:0];
      5'd18:   hdr_byte = head.len[15:8];
      5'd19:   hdr_byte = head.len[7:0];
      default: hdr_byte = kip_pkg::HDR_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hidx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        hidx <= at_payload ? '0 : hidx + kip_pkg::HIDX_W'(1);
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= at_payload ? head.data : hdr_byte;
      packet_end <= at_payload && head.pe;
      zero_fill <= at_payload ? head.fill : '0;
      image_end <= at_payload && head.ie;
      run_last <= at_payload;
    end
  end

endmodule

`default_nettype wire

// ===== design/key_image_packetizer.sv =====
// Top level of the key image packetizer: configuration registers, front end, queue, back end.
`default_nettype none

// Frames a byte stream of key images into report packets of PACKET_SIZE bytes. Output words
// leave at one per cycle while out_stall is low, from a registered output stage. A plain
// payload word gives one output word, the first word of a later packet six (five header words
// and the payload word), and the first word of an image twenty-one. Input words are taken
// every cycle while the two-entry command queue between the front end and the byte emitter
// has room, so header bursts stall the input; dropped images and their bytes give no output.
// Padding is not sent; its length rides on zero_fill of each packet's last payload word.
module key_image_packetizer #(
  parameter int PACKET_SIZE = 4095,
  parameter int GRID_COLUMNS = 3
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [kip_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [kip_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [kip_pkg::BYTE_W-1:0] data_byte,
  input  wire logic [kip_pkg::KEY_W-1:0] key_index,
  input  wire logic [kip_pkg::LEN_W-1:0] image_length,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [kip_pkg::BYTE_W-1:0] out_byte,
  output logic packet_end,
  output logic [kip_pkg::PKT_W-1:0] zero_fill,
  output logic image_end,
  output logic run_last
);

  logic [kip_pkg::POS_W-1:0] origin_x, origin_y, tile_size;
  logic [kip_pkg::PITCH_W-1:0] key_pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= kip_pkg::ORIGIN_X_RST;
      origin_y <= kip_pkg::ORIGIN_Y_RST;
      key_pitch <= kip_pkg::KEY_PITCH_RST;
      tile_size <= kip_pkg::TILE_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kip_pkg::REG_ORIGIN_X:  origin_x <= cfg_data;
        kip_pkg::REG_ORIGIN_Y:  origin_y <= cfg_data;
        kip_pkg::REG_KEY_PITCH: key_pitch <= cfg_data[kip_pkg::PITCH_W-1:0];
        kip_pkg::REG_TILE_SIZE: tile_size <= cfg_data;
        default: ;
      endcase
    end
  end

  kip_pkg::kip_entry_t push_entry, head;
  kip_pkg::kip_q_status_t q_status;
  logic push, pop, accept;

  assign in_stall = q_status.full;
  assign accept = in_valid && !in_stall;

  kip_front #(
    .PACKET_SIZE(PACKET_SIZE),
    .GRID_COLUMNS(GRID_COLUMNS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .data_byte(data_byte),
    .key_index(key_index),
    .image_length(image_length),
    .origin_x(origin_x),
    .origin_y(origin_y),
    .key_pitch(key_pitch),
    .entry(push_entry),
    .push(push)
  );

  kip_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_entry(push_entry),
    .pop(pop),
    .head(head),
    .status(q_status)
  );

  kip_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .head_valid(q_status.head_valid),
    .tile_size(tile_size),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .packet_end(packet_end),
    .zero_fill(zero_fill),
    .image_end(image_end),
    .run_last(run_last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full && !pop))
    else $error("Command queue written while full.");

  a_header_plain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_last |-> !packet_end && !image_end && zero_fill == '0)
    else $error("Header word carries payload flags.");

  a_fill_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !packet_end |-> zero_fill == '0)
    else $error("Fill count away from packet end.");

  a_image_end_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_end |-> packet_end)
    else $error("Image ended inside a packet.");

endmodule

`default_nettype wire
